// ----- hw/rtl/sdn_pkg.sv -----
// ----------------------------------------------------------------------------
// sdn_pkg
// Types, constants and saturating helpers for the spring-damper nudge
// integrator.
// ----------------------------------------------------------------------------
package sdn_pkg;

	localparam int DATA_WIDTH    = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int CFG_WIDTH     = DATA_WIDTH - 1;
	localparam int CFG_IDX_WIDTH = 3;

	typedef logic signed [DATA_WIDTH-1:0] fix_t;
	typedef logic [CFG_WIDTH-1:0]         cfg_word_t;

	localparam fix_t FIX_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam fix_t FIX_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_NUDGE = 1'b1;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		CFG_SPRING_K  = 3'd0,
		CFG_DAMPING_C = 3'd1,
		CFG_TIME_STEP = 3'd2,
		CFG_INV_STEP  = 3'd3,
		CFG_VEL_MODE  = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic req_type;
		fix_t impulse_x;
		fix_t impulse_y;
		fix_t sensor_x;
		fix_t sensor_y;
	} req_t;

	typedef struct packed {
		fix_t accel_x;
		fix_t accel_y;
		fix_t screen_x;
		fix_t screen_y;
		fix_t direct_accel_x;
		fix_t direct_accel_y;
	} rsp_t;

	typedef struct packed {
		cfg_word_t spring_k;
		cfg_word_t damping_c;
		cfg_word_t time_step;
		cfg_word_t inv_time_step;
		logic      velocity_mode;
	} cfg_t;

	typedef struct packed {
		logic start;
		fix_t a;
		fix_t b;
	} mul_req_t;

	typedef struct packed {
		logic done;
		fix_t p;
	} mul_rsp_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_sts_t;

	typedef enum logic [1:0] {
		MS_IDLE,
		MS_RUN,
		MS_FIN
	} mul_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KD,
		ST_CV,
		ST_DF,
		ST_DV,
		ST_AC,
		ST_SV,
		ST_DONE
	} core_state_t;

	typedef logic signed [DATA_WIDTH+1:0] wide_t;

	function automatic wide_t sx(input fix_t a);
		return {{2{a[DATA_WIDTH-1]}}, a};
	endfunction

	function automatic fix_t sat_wide(input wide_t v);
		fix_t r;
		if (v[DATA_WIDTH+1] == v[DATA_WIDTH] && v[DATA_WIDTH] == v[DATA_WIDTH-1])
			r = v[DATA_WIDTH-1:0];
		else
			r = v[DATA_WIDTH+1] ? FIX_MIN : FIX_MAX;
		return r;
	endfunction

	function automatic fix_t sat_add(input fix_t a, input fix_t b);
		return sat_wide(sx(a) + sx(b));
	endfunction

	function automatic fix_t sat_sub(input fix_t a, input fix_t b);
		return sat_wide(sx(a) - sx(b));
	endfunction

	// -a - b, saturated
	function automatic fix_t sat_neg_sub(input fix_t a, input fix_t b);
		return sat_wide(wide_t'(0) - sx(a) - sx(b));
	endfunction

endpackage

// ----- hw/rtl/spring_damper_nudge_integrator.sv -----
// ----------------------------------------------------------------------------
// spring_damper_nudge_integrator
// Two-axis mass-spring-damper table model in signed fixed point with
// nudge impulses and semi-implicit Euler ticks.
//
//   channel   valid       stall       payload
//   request   req_valid   req_stall   req_data (req_t)
//   result    rsp_valid   rsp_stall   rsp_data (rsp_t)
//   config    cfg_we      -           cfg_index, cfg_data
//
// A nudge updates velocity on acceptance and goes straight to done. A tick
// runs 5 products per axis (6 in velocity mode) on one bit-serial multiplier,
// one product after another, for both axes in turn.
// req_stall is high from acceptance until the result moves to the output
// register, which holds it under rsp_stall while the next request is taken.
// Reset clears state and loads the register defaults.
// ----------------------------------------------------------------------------
module spring_damper_nudge_integrator import sdn_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  req_t                     req_data,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output rsp_t                     rsp_data,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
	input  logic [CFG_WIDTH-1:0]     cfg_data
);

	cfg_t      cfg_q;
	logic      rsp_valid_q;
	rsp_t      rsp_q;
	core_sts_t sts;
	rsp_t      core_rsp;
	logic      accept;
	logic      take;

	assign req_stall = sts.busy;
	assign accept    = req_valid && !req_stall;
	assign take      = sts.done && (!rsp_valid_q || !rsp_stall);

	sdn_core #(.FRAC_BITS(FRAC_BITS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.req    (req_data),
		.take   (take),
		.cfg    (cfg_q),
		.sts    (sts),
		.rsp    (core_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spring_k      <= '0;
			cfg_q.damping_c     <= '0;
			cfg_q.time_step     <= CFG_WIDTH'(1) << (FRAC_BITS - 1);
			cfg_q.inv_time_step <= CFG_WIDTH'(2) << FRAC_BITS;
			cfg_q.velocity_mode <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_SPRING_K:  cfg_q.spring_k      <= cfg_data;
				CFG_DAMPING_C: cfg_q.damping_c     <= cfg_data;
				CFG_TIME_STEP: cfg_q.time_step     <= cfg_data;
				CFG_INV_STEP:  cfg_q.inv_time_step <= cfg_data;
				CFG_VEL_MODE:  cfg_q.velocity_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rsp_valid_q <= 1'b0;
		else if (take)
			rsp_valid_q <= 1'b1;
		else if (!rsp_stall)
			rsp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (take)
			rsp_q <= core_rsp;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> sts.busy)
		else $error("core not busy after request accepted");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> !sts.done && !sts.busy)
		else $error("core did not return to idle after hand-off");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp_valid)
		else $error("result lost on hand-off to output register");

endmodule

// ----- hw/rtl/sdn_mul.sv -----
// ----------------------------------------------------------------------------
// sdn_mul
// Bit-serial fixed-point multiplier: one multiplier bit per cycle, floor
// scaling by 2^FRAC_BITS and saturation in a final step.
// ----------------------------------------------------------------------------
module sdn_mul import sdn_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t mreq,
	output mul_rsp_t mrsp
);

	localparam int W  = DATA_WIDTH;
	localparam int CW = $clog2(W + 1);
	localparam logic [W:0] HALF = (W + 1)'(1) << (W - 1);

	mul_state_t st_q, st_d;
	logic [CW-1:0]  cnt_q;
	logic [W-1:0]   mcand_q;
	logic [2*W:0]   prod_q;
	logic           neg_q;
	fix_t           p_q;
	logic           done_q;

	logic [W-1:0]   ma, mb;
	logic [W:0]     sum;
	logic [2*W-1:0] full;
	logic           upper, rem;
	logic [W:0]     qa;
	fix_t           res;

	assign ma = mreq.a[W-1] ? (~mreq.a + W'(1)) : mreq.a;
	assign mb = mreq.b[W-1] ? (~mreq.b + W'(1)) : mreq.b;
	assign sum = prod_q[2*W:W] + (prod_q[0] ? {1'b0, mcand_q} : (W + 1)'(0));

	assign full  = prod_q[2*W-1:0];
	assign upper = |full[2*W-1:FRAC_BITS+W];
	assign rem   = |full[FRAC_BITS-1:0];
	assign qa    = {1'b0, full[FRAC_BITS+W-1:FRAC_BITS]} + (W + 1)'(neg_q & rem);

	always_comb begin
		if (neg_q) begin
			if (upper || qa > HALF)
				res = FIX_MIN;
			else
				res = -qa[W-1:0];
		end else begin
			if (upper || qa[W] || qa[W-1])
				res = FIX_MAX;
			else
				res = qa[W-1:0];
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			MS_IDLE: if (mreq.start) st_d = MS_RUN;
			MS_RUN:  if (cnt_q == CW'(1)) st_d = MS_FIN;
			MS_FIN:  st_d = MS_IDLE;
			default: st_d = MS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= MS_IDLE;
			done_q <= 1'b0;
		end else begin
			st_q   <= st_d;
			done_q <= (st_q == MS_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			MS_IDLE: begin
				if (mreq.start) begin
					mcand_q <= ma;
					prod_q  <= {(W + 1)'(0), mb};
					neg_q   <= mreq.a[W-1] ^ mreq.b[W-1];
					cnt_q   <= CW'(W);
				end
			end
			MS_RUN: begin
				prod_q <= {1'b0, sum, prod_q[W-1:1]};
				cnt_q  <= cnt_q - CW'(1);
			end
			MS_FIN: p_q <= res;
			default: ;
		endcase
	end

	assign mrsp.done = done_q;
	assign mrsp.p    = p_q;

endmodule

// ----- hw/rtl/sdn_core.sv -----
// ----------------------------------------------------------------------------
// sdn_core
// Sequencer and table state: steps each axis through the chain of products
// on the shared serial multiplier; nudges update velocity directly.
// ----------------------------------------------------------------------------
module sdn_core import sdn_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  req_t      req,
	input  logic      take,
	input  cfg_t      cfg,
	output core_sts_t sts,
	output rsp_t      rsp
);

	core_state_t st_q, st_d;
	logic     ax_q;
	logic     wait_q;
	req_t     item_q;
	fix_t     tmp_q;
	fix_t     old_q;
	fix_t     vel_q  [2];
	fix_t     disp_q [2];
	fix_t     acc_q  [2];
	fix_t     prev_q [2];
	fix_t     dir_q  [2];

	mul_req_t mreq;
	mul_rsp_t mrsp;
	logic     op_st;
	logic     fin;
	fix_t     vel, disp, sensor;

	sdn_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mreq),
		.mrsp   (mrsp)
	);

	assign vel    = vel_q[ax_q];
	assign disp   = disp_q[ax_q];
	assign sensor = ax_q ? item_q.sensor_y : item_q.sensor_x;
	assign op_st  = st_q inside {ST_KD, ST_CV, ST_DF, ST_DV, ST_AC, ST_SV};
	assign fin    = wait_q && mrsp.done;

	always_comb begin
		mreq.start = op_st && !wait_q;
		mreq.a     = fix_t'({1'b0, cfg.spring_k});
		mreq.b     = disp;
		case (st_q)
			ST_CV: begin
				mreq.a = fix_t'({1'b0, cfg.damping_c});
				mreq.b = vel;
			end
			ST_DF: begin
				mreq.a = fix_t'({1'b0, cfg.time_step});
				mreq.b = tmp_q;
			end
			ST_DV: begin
				mreq.a = fix_t'({1'b0, cfg.time_step});
				mreq.b = vel;
			end
			ST_AC: begin
				mreq.a = sat_sub(vel, old_q);
				mreq.b = fix_t'({1'b0, cfg.inv_time_step});
			end
			ST_SV: begin
				mreq.a = sat_sub(sensor, prev_q[ax_q]);
				mreq.b = fix_t'({1'b0, cfg.inv_time_step});
			end
			default: ;
		endcase
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (start) st_d = (req.req_type == REQ_NUDGE) ? ST_DONE : ST_KD;
			ST_KD:   if (fin) st_d = ST_CV;
			ST_CV:   if (fin) st_d = ST_DF;
			ST_DF:   if (fin) st_d = ST_DV;
			ST_DV:   if (fin) st_d = ST_AC;
			ST_AC: begin
				if (fin) begin
					if (cfg.velocity_mode)
						st_d = ST_SV;
					else
						st_d = ax_q ? ST_DONE : ST_KD;
				end
			end
			ST_SV:   if (fin) st_d = ax_q ? ST_DONE : ST_KD;
			ST_DONE: if (take) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			ax_q   <= 1'b0;
			wait_q <= 1'b0;
			vel_q  <= '{default: '0};
			disp_q <= '{default: '0};
			acc_q  <= '{default: '0};
			prev_q <= '{default: '0};
			dir_q  <= '{default: '0};
		end else begin
			st_q <= st_d;
			if (mreq.start)
				wait_q <= 1'b1;
			else if (mrsp.done)
				wait_q <= 1'b0;
			if (st_q == ST_IDLE && start) begin
				ax_q <= 1'b0;
				if (req.req_type == REQ_NUDGE) begin
					vel_q[0] <= sat_add(vel_q[0], req.impulse_x);
					vel_q[1] <= sat_sub(vel_q[1], req.impulse_y);
				end
			end
			if (fin) begin
				case (st_q)
					ST_DF: vel_q[ax_q]  <= sat_add(vel, mrsp.p);
					ST_DV: disp_q[ax_q] <= sat_add(disp, mrsp.p);
					ST_AC: begin
						acc_q[ax_q] <= mrsp.p;
						if (!cfg.velocity_mode) begin
							dir_q[ax_q] <= sensor;
							ax_q        <= 1'b1;
						end
					end
					ST_SV: begin
						acc_q[ax_q]  <= sat_add(acc_q[ax_q], mrsp.p);
						prev_q[ax_q] <= sensor;
						dir_q[ax_q]  <= '0;
						ax_q         <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && start)
			item_q <= req;
		if (fin) begin
			case (st_q)
				ST_KD: tmp_q <= mrsp.p;
				ST_CV: tmp_q <= sat_neg_sub(tmp_q, mrsp.p);
				ST_DF: old_q <= vel;
				default: ;
			endcase
		end
	end

	assign sts.busy = (st_q != ST_IDLE);
	assign sts.done = (st_q == ST_DONE);

	assign rsp.accel_x        = acc_q[0];
	assign rsp.accel_y        = acc_q[1];
	assign rsp.screen_x       = disp_q[0];
	assign rsp.screen_y       = sat_sub('0, disp_q[1]);
	assign rsp.direct_accel_x = dir_q[0];
	assign rsp.direct_accel_y = dir_q[1];

endmodule
